// ----- src/sus_pkg.sv -----
// types and codes shared by the sorted unique set unit
package sus_pkg;

	localparam int unsigned REQW  = 2;
	localparam int unsigned VALW  = 32;
	localparam int unsigned IDXW  = 5;
	localparam int unsigned STATW = 2;
	localparam int unsigned CNTW  = 6;

	localparam logic [REQW-1:0] REQ_INS  = 2'd0;
	localparam logic [REQW-1:0] REQ_DEL  = 2'd1;
	localparam logic [REQW-1:0] REQ_READ = 2'd2;

	localparam logic [STATW-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATW-1:0] STAT_NOCHG = 2'd1;
	localparam logic [STATW-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATW-1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic        [REQW-1:0] req_type;
		logic signed [VALW-1:0] value;
		logic        [IDXW-1:0] index;
	} req_t;

	typedef struct packed {
		logic        [STATW-1:0] status;
		logic signed [VALW-1:0]  read_value;
		logic        [CNTW-1:0]  count;
	} res_t;

endpackage

// ----- src/sorted_unique_set_unit.sv -----
// sorted unique set: ascending store of distinct values in one memory
//
//   channel   ports                 handshake
//   request   start, busy, req      item taken when start && !busy
//   result    done, res             done high for one cycle per item, no stall
//
// insert and delete scan the memory from the bottom, one read issued per cycle,
// then move the tail up or down one entry per cycle through the single
// read/write port pair.
// a read by index passes through the readout state; type 3 and out-of-range reads are answered straight from idle.
// reset clears the element count; memory contents need no clearing.
// results are registered, so a new item may be taken while one is shown.
module sorted_unique_set_unit #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sus_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output sus_pkg::res_t res
);
	import sus_pkg::*;

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > IDXW) ? CW : IDXW;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_PUT    = 5'b01000,
		S_RDOUT  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic        [CW-1:0]   count_q;
	logic        [REQW-1:0] op_q;
	logic signed [VALW-1:0] val_q;
	logic        [CW-1:0]   ptr_q;
	logic        [CW-1:0]   left_q;
	logic        [CW-1:0]   pos_q;
	logic                   done_q;
	res_t                   res_q;

	logic                   rv_s1;
	logic        [AW-1:0]   ra_s1;
	logic signed [VALW-1:0] rdata_s1;

	logic signed [VALW-1:0] mem [CAPACITY];

	logic                   rd_en;
	logic        [AW-1:0]   rd_addr;
	logic                   wr_en;
	logic        [AW-1:0]   wr_addr;
	logic signed [VALW-1:0] wr_data;

	logic                   hit;
	logic                   scan_end;
	logic        [CW-1:0]   found_pos;
	logic                   found_eq;
	logic                   idx_ok;

	function automatic res_t mk_res(logic [STATW-1:0] st, logic signed [VALW-1:0] rv,
			logic [CW-1:0] c);
		res_t r;
		r.status     = st;
		r.read_value = rv;
		r.count      = CNTW'(c);
		return r;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	assign hit       = rv_s1 && !(rdata_s1 < val_q);
	assign scan_end  = hit || (!rv_s1 && !(ptr_q < count_q));
	assign found_pos = hit ? CW'(ra_s1) : count_q;
	assign found_eq  = hit && (rdata_s1 == val_q);
	assign idx_ok    = CMPW'(req.index) < CMPW'(count_q);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = ra_s1;
		wr_data = rdata_s1;
		case (state_q)
			S_IDLE: begin
				rd_addr = AW'(req.index);
				rd_en   = start && (req.req_type == REQ_READ);
			end
			S_SEARCH: begin
				rd_en = ptr_q < count_q;
			end
			S_SHIFT: begin
				rd_en   = left_q != '0;
				wr_en   = rv_s1;
				wr_addr = (op_q == REQ_INS) ? ra_s1 + AW'(1) : ra_s1 - AW'(1);
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			op_q    <= '0;
			val_q   <= '0;
			ptr_q   <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
			rv_s1   <= 1'b0;
			ra_s1   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					rv_s1 <= 1'b0;
					ptr_q <= '0;
					if (start) begin
						op_q  <= req.req_type;
						val_q <= req.value;
						case (req.req_type)
							REQ_INS, REQ_DEL: begin
								state_q <= S_SEARCH;
							end
							REQ_READ: begin
								if (idx_ok) begin
									state_q <= S_RDOUT;
								end else begin
									done_q <= 1'b1;
									res_q  <= mk_res(STAT_RANGE, '0, count_q);
								end
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= mk_res(STAT_NOCHG, '0, count_q);
							end
						endcase
					end
				end
				S_SEARCH: begin
					rv_s1 <= rd_en;
					ra_s1 <= rd_addr;
					if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (scan_end) begin
						rv_s1 <= 1'b0;
						pos_q <= found_pos;
						if (op_q == REQ_INS) begin
							if (found_eq) begin
								done_q  <= 1'b1;
								res_q   <= mk_res(STAT_NOCHG, '0, count_q);
								state_q <= S_IDLE;
							end else if (count_q == CW'(CAPACITY)) begin
								done_q  <= 1'b1;
								res_q   <= mk_res(STAT_FULL, '0, count_q);
								state_q <= S_IDLE;
							end else begin
								left_q  <= count_q - found_pos;
								ptr_q   <= count_q - CW'(1);
								state_q <= S_SHIFT;
							end
						end else begin
							if (!found_eq) begin
								done_q  <= 1'b1;
								res_q   <= mk_res(STAT_NOCHG, '0, count_q);
								state_q <= S_IDLE;
							end else begin
								left_q  <= count_q - found_pos - CW'(1);
								ptr_q   <= found_pos + CW'(1);
								state_q <= S_SHIFT;
							end
						end
					end
				end
				S_SHIFT: begin
					rv_s1 <= rd_en;
					ra_s1 <= rd_addr;
					if (rd_en) begin
						left_q <= left_q - CW'(1);
						ptr_q  <= (op_q == REQ_INS) ? ptr_q - CW'(1) : ptr_q + CW'(1);
					end
					if (!rd_en && !rv_s1) begin
						if (op_q == REQ_INS) begin
							state_q <= S_PUT;
						end else begin
							count_q <= count_q - CW'(1);
							done_q  <= 1'b1;
							res_q   <= mk_res(STAT_DONE, '0, count_q - CW'(1));
							state_q <= S_IDLE;
						end
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					res_q   <= mk_res(STAT_DONE, '0, count_q + CW'(1));
					state_q <= S_IDLE;
				end
				S_RDOUT: begin
					done_q  <= 1'b1;
					res_q   <= mk_res(STAT_DONE, rdata_s1, count_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
